/* hdl/packet_crc_continuity_checker_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packet CRC continuity checker
// Shared forms for concurrent assertions clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef PACKET_CRC_CONTINUITY_CHECKER_UNIT_MACROS_SVH
`define PACKET_CRC_CONTINUITY_CHECKER_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high
`define PCCC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked through reset
`define PCCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pccc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pccc_pkg
// Types, constants and the CRC-16 byte update shared by the packet CRC
// continuity checker.
// ----------------------------------------------------------------------------
package pccc_pkg;

   // CRC-16, MSB first
   localparam logic [15:0] CRC_PRESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   // byte counter: idle means past the end of the packet
   localparam logic [8:0]  CNT_IDLE   = 9'h1FF;
   localparam logic [7:0]  LEN_RESET  = 8'd1;

   // header byte masks
   localparam logic [7:0]  HDR_FIRST  = 8'h80;
   localparam logic [7:0]  HDR_LAST   = 8'h40;
   localparam logic [7:0]  HDR_PID    = 8'h30;
   localparam logic [7:0]  HDR_PPI    = 8'h08;
   localparam logic [7:0]  HDR_CI     = 8'h07;

   // result codes
   localparam logic [2:0]  ACT_FIRST      = 3'd0;
   localparam logic [2:0]  ACT_LAST       = 3'd1;
   localparam logic [2:0]  ACT_MIDDLE     = 3'd2;
   localparam logic [2:0]  ACT_CONT_RESET = 3'd3;
   localparam logic [2:0]  ACT_CRC_FAIL   = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       segment_start;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] packet_id;
      logic       pointer_present;
      logic [2:0] continuity_index;
      logic       first_flag;
      logic       last_flag;
      logic [7:0] useful_bytes;
   } rsp_type;

   // input register contents handed to the tracker
   typedef struct packed {
      logic    valid;
      req_type data;
   } stage_type;

   // one byte through the CRC, eight bit steps, optional bit inversion
   function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                   input logic [7:0]  data_in,
                                                   input logic        invert);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int b = 7; b >= 0; b--) begin
         fb = c[15] ^ data_in[b] ^ invert;
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

/* hdl/pccc_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pccc_in_reg
// Input register: holds one request beat until the tracker consumes it.
// ----------------------------------------------------------------------------
module pccc_in_reg import pccc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      advance,
   output stage_type stage
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   // take a new beat when empty or when the held one moves on
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

/* hdl/pccc_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pccc_track
// Packet tracker: byte counter, CRC, header capture, continuity check and
// the result register.
// ----------------------------------------------------------------------------
module pccc_track import pccc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage,
   input  logic [7:0] packet_length,
   output logic      advance,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic [8:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [7:0]  sec_ff, sec_in;
   logic [2:0]  exp_ff, exp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [8:0]  total;
   logic [8:0]  pos;
   logic [15:0] crc_base;
   logic        active;
   logic        emit;
   logic        first, last, ppi;
   logic [2:0]  ci;

   // a beat moves on when the result slot is free or being emptied
   assign advance = stage.valid && (!rsp_valid_ff || rsp_ready);

   assign total    = {1'b0, packet_length} + 9'd3;
   assign pos      = stage.data.segment_start ? 9'd0 : cnt_ff;
   assign crc_base = stage.data.segment_start ? CRC_PRESET : crc_ff;
   assign active   = pos < total;
   assign emit     = advance && active && ((pos + 9'd1) >= total);

   // header fields of the stored first byte
   assign first = |(hdr_ff & HDR_FIRST);
   assign last  = |(hdr_ff & HDR_LAST);
   assign ppi   = |(hdr_ff & HDR_PPI);
   assign ci    = hdr_ff[2:0] & HDR_CI[2:0];

   // per-byte state update
   always_comb begin
      cnt_in = cnt_ff;
      crc_in = crc_ff;
      hdr_in = hdr_ff;
      sec_in = sec_ff;
      if (advance) begin
         crc_in = crc_base;
         if (!active) begin
            cnt_in = CNT_IDLE;
         end else begin
            if (pos == 9'd0) begin
               hdr_in = stage.data.data_byte;
            end else if (pos == 9'd1) begin
               sec_in = stage.data.data_byte;
            end
            crc_in = crc_byte_update(crc_base, stage.data.data_byte,
                                     (pos + 9'd2) >= total);
            cnt_in = ((pos + 9'd1) < total) ? pos + 9'd1 : CNT_IDLE;
         end
      end
   end

   // verdict and result beat
   always_comb begin
      exp_in                       = exp_ff;
      rsp_data_in                  = rsp_data_ff;
      rsp_valid_in                 = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_data_in.packet_id        = hdr_ff[5:4] & HDR_PID[5:4];
         rsp_data_in.pointer_present  = ppi;
         rsp_data_in.continuity_index = ci;
         rsp_data_in.first_flag       = first;
         rsp_data_in.last_flag        = last;
         rsp_data_in.useful_bytes     = ppi ? sec_ff : packet_length - 8'd1;
         if (crc_in != 16'd0) begin
            rsp_data_in.action = ACT_CRC_FAIL;
         end else if (ci == exp_ff) begin
            exp_in = ci + 3'd1;
            if (first && !last) begin
               rsp_data_in.action = ACT_FIRST;
            end else if (last && !first) begin
               rsp_data_in.action = ACT_LAST;
            end else begin
               rsp_data_in.action = ACT_MIDDLE;
            end
         end else begin
            exp_in             = 3'd0;
            rsp_data_in.action = ACT_CONT_RESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= CNT_IDLE;
         crc_ff       <= CRC_PRESET;
         hdr_ff       <= 8'd0;
         sec_ff       <= 8'd0;
         exp_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         hdr_ff       <= hdr_in;
         sec_ff       <= sec_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/packet_crc_continuity_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_crc_continuity_checker_unit
// Checks CRC-16 and header continuity of packet-mode segments, one byte per
// beat, and gives one result beat per completed packet.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | req_data (byte, segment start)
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_data (action, header, count)
//  csr     | in        | csr_wr_en             | csr_wr_data (packet length)
//
// One byte per cycle sustained while no result stalls; a byte passes the
// input register, then the tracker; the result register is loaded as the
// last byte moves on. The combinational CRC byte update sets the rate.
// Reset (synchronous) empties both registers and makes the tracker idle.
// A stalled result holds in the result register; the input register keeps
// taking beats until it also fills.
// ----------------------------------------------------------------------------
module packet_crc_continuity_checker_unit import pccc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0] len_ff, len_in;
   stage_type  stage;
   logic       advance;

   // packet length register
   assign len_in = csr_wr_en ? csr_wr_data : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   pccc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .stage     (stage)
   );

   pccc_track u_track (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .packet_length (len_ff),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

/* hdl/pccc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pccc_checker
// Port-level assertions for the packet CRC continuity checker, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "packet_crc_continuity_checker_unit_macros.svh"

module pccc_checker import pccc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   `PCCC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // no result right after reset
   `PCCC_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // only defined action codes appear
   `PCCC_ASSERT(a_action_code, clock, reset, rsp_valid |-> rsp_data.action <= ACT_CRC_FAIL, "bad action code")

   // first/last classes agree with the header flags
   `PCCC_ASSERT(a_class_first, clock, reset, rsp_valid && rsp_data.action == ACT_FIRST |-> rsp_data.first_flag && !rsp_data.last_flag, "first class with wrong flags")
   `PCCC_ASSERT(a_class_last, clock, reset, rsp_valid && rsp_data.action == ACT_LAST |-> rsp_data.last_flag && !rsp_data.first_flag, "last class with wrong flags")

endmodule

bind packet_crc_continuity_checker_unit pccc_checker u_pccc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/sv/packet_verdict_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_verdict_check
// Watches the byte and result channels of the packet CRC continuity checker.
// It mirrors the packet tracker: byte position, CRC-16, header, second byte
// and expected continuity index. Every completed packet queues a verdict,
// and each result beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module packet_verdict_check import pccc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         error_count,
   output int         verdicts_pending
);

   // mirrored tracker state
   logic [7:0]  length_reg;
   logic [8:0]  byte_pos;
   logic [15:0] crc_reg;
   logic [7:0]  header_byte;
   logic [7:0]  second_byte;
   logic [2:0]  next_index;

   rsp_type     verdicts_due [$];

   // CRC-16 over one byte, MSB first, byte folded into the top of the register
   function automatic logic [15:0] crc_advance(input logic [15:0] crc,
                                               input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // one accepted byte beat through the packet tracker
   task automatic track_byte(input req_type beat);
      int      total_len;
      rsp_type v;
      total_len = int'(length_reg) + 3;
      if (beat.segment_start) begin
         byte_pos = '0;
         crc_reg  = CRC_PRESET;
      end
      if (int'(byte_pos) >= total_len) begin
         // past the packet end: ignored
         byte_pos = CNT_IDLE;
      end else begin
         if (byte_pos == 9'd0) begin
            header_byte = beat.data_byte;
         end else if (byte_pos == 9'd1) begin
            second_byte = beat.data_byte;
         end
         // the two CRC bytes enter inverted
         crc_reg = crc_advance(crc_reg, (int'(byte_pos) + 2 >= total_len) ?
                               ~beat.data_byte : beat.data_byte);
         if (int'(byte_pos) + 1 < total_len) begin
            byte_pos = byte_pos + 9'd1;
         end else begin
            byte_pos           = CNT_IDLE;
            v.first_flag       = header_byte[7];
            v.last_flag        = header_byte[6];
            v.packet_id        = header_byte[5:4];
            v.pointer_present  = header_byte[3];
            v.continuity_index = header_byte[2:0];
            v.useful_bytes     = header_byte[3] ? second_byte : length_reg - 8'd1;
            if (crc_reg != 16'h0000) begin
               v.action = ACT_CRC_FAIL;
            end else if (header_byte[2:0] == next_index) begin
               next_index = header_byte[2:0] + 3'd1;
               if (v.first_flag && !v.last_flag) begin
                  v.action = ACT_FIRST;
               end else if (v.last_flag && !v.first_flag) begin
                  v.action = ACT_LAST;
               end else begin
                  v.action = ACT_MIDDLE;
               end
            end else begin
               next_index = '0;
               v.action   = ACT_CONT_RESET;
            end
            verdicts_due.push_back(v);
         end
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         length_reg  = LEN_RESET;
         byte_pos    = CNT_IDLE;
         crc_reg     = CRC_PRESET;
         header_byte = '0;
         second_byte = '0;
         next_index  = '0;
         verdicts_due.delete();
      end else begin
         if (csr_wr_en) begin
            length_reg = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            track_byte(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               error_count++;
               $display("%0t ns: result beat with none expected, expected nothing, got %h",
                        $time, rsp_data);
            end else begin
               want = verdicts_due.pop_front();
               compare_field("action", want.action, rsp_data.action);
               compare_field("packet_id", want.packet_id, rsp_data.packet_id);
               compare_field("pointer_present", want.pointer_present,
                             rsp_data.pointer_present);
               compare_field("continuity_index", want.continuity_index,
                             rsp_data.continuity_index);
               compare_field("first_flag", want.first_flag, rsp_data.first_flag);
               compare_field("last_flag", want.last_flag, rsp_data.last_flag);
               compare_field("useful_bytes", want.useful_bytes, rsp_data.useful_bytes);
            end
         end
      end
      verdicts_pending <= verdicts_due.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives packet-mode byte streams into the packet CRC continuity checker
// under several packet lengths and idle patterns, and gives the verdict
// from the failure count and the pending verdicts of the verdict checker.
// ----------------------------------------------------------------------------
module tb import pccc_pkg::*; ();

   localparam int STALL_CYCLES = 80;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PAUSE_CYCLES = 4;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = '0;

   int         error_count;
   int         results_pending;

   // traffic shaping
   int         send_idle_pct = 32;
   int         recv_idle_pct = 58;
   bit         hold_rsp      = 1'b0;

   // stream state on the sending side
   logic [7:0] cur_len       = LEN_RESET;
   logic [2:0] gen_ci        = '0;
   bit         mid_packet    = 1'b0;
   int         packet_beats  = 0;

   packet_crc_continuity_checker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   packet_verdict_check verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (error_count),
      .verdicts_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // one byte beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [7:0] data, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: data, segment_start: start};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // builds one packet with a good CRC, then optionally corrupts or cuts it
   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] second,
                              input bit corrupt, input bit cut);
      logic [7:0]  pkt [$];
      logic [15:0] crc;
      int          total;
      int          keep;
      int          pos;
      total = int'(cur_len) + 3;
      crc   = CRC_PRESET;
      for (int i = 0; i <= int'(cur_len); i++) begin
         pkt.push_back(i == 0 ? hdr : (i == 1 ? second : 8'($urandom)));
         crc = crc ^ {pkt[i], 8'h00};
         repeat (8) crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
      end
      // sent inverted so the receiver's remainder comes out zero
      pkt.push_back(~crc[15:8]);
      pkt.push_back(~crc[7:0]);
      if (corrupt) begin
         pos      = $urandom_range(total - 1);
         pkt[pos] = pkt[pos] ^ (8'd1 << $urandom_range(7));
      end
      keep = cut ? $urandom_range(1, total - 1) : total;
      for (int i = 0; i < keep; i++) begin
         send_beat(pkt[i], i == 0);
         packet_beats++;
      end
      mid_packet = cut;
      if (!cut && !corrupt) begin
         gen_ci = (hdr[2:0] == gen_ci) ? gen_ci + 3'd1 : 3'd0;
      end
   endtask

   // mostly well-formed packets in sequence, plus bad CRC, broken
   // continuity, cut segments and stray bytes
   task automatic random_traffic(input int budget);
      int         stop_at;
      int         pick;
      logic [7:0] hdr;
      stop_at = packet_beats + budget;
      while (packet_beats < stop_at) begin
         pick     = $urandom_range(99);
         hdr      = 8'($urandom);
         hdr[2:0] = gen_ci;
         if (pick < 70) begin
            send_packet(hdr, 8'($urandom), 1'b0, 1'b0);
         end else if (pick < 80) begin
            hdr[2:0] = gen_ci + 3'($urandom_range(1, 7));
            send_packet(hdr, 8'($urandom), 1'b0, 1'b0);
         end else if (pick < 88) begin
            send_packet(hdr, 8'($urandom), 1'b1, 1'b0);
         end else if (pick < 94) begin
            send_packet(hdr, 8'($urandom), 1'b0, 1'b1);
         end else if (!mid_packet) begin
            repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b0);
         end
      end
      // leave the tracker idle
      if (mid_packet) begin
         hdr      = 8'($urandom);
         hdr[2:0] = gen_ci;
         send_packet(hdr, 8'($urandom), 1'b0, 1'b0);
      end
   endtask

   // stop sending until every verdict is back and the pipe is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (PAUSE_CYCLES) @(posedge clock);
   endtask

   task automatic set_length(input logic [7:0] len);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      cur_len      = len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [7:0] hdr;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: stray byte, each class, CRC fail, continuity reset, cut segment
      send_beat(8'h00, 1'b0);
      send_packet({1'b1, 1'b0, 2'd0, 1'b0, gen_ci}, 8'h00, 1'b0, 1'b0);
      send_packet({1'b0, 1'b1, 2'd3, 1'b1, gen_ci}, 8'hFF, 1'b0, 1'b0);
      send_packet({1'b1, 1'b1, 2'd2, 1'b0, gen_ci}, 8'h5A, 1'b0, 1'b0);
      send_packet({1'b0, 1'b0, 2'd1, 1'b1, gen_ci}, 8'hA5, 1'b1, 1'b0);
      send_packet({1'b0, 1'b0, 2'd0, 1'b0, gen_ci + 3'd5}, 8'h3C, 1'b0, 1'b0);
      send_packet(8'hFF, 8'hFF, 1'b0, 1'b1);
      send_packet({1'b0, 1'b0, 2'd1, 1'b0, gen_ci}, 8'h00, 1'b0, 1'b0);

      random_traffic(200);
      // zero length: CRC bytes follow the header directly
      set_length(8'd0);
      random_traffic(120);

      send_idle_pct = 58;
      recv_idle_pct = 32;
      // longest packets, with and without pointer
      set_length(8'd255);
      hdr = {2'($urandom), 2'($urandom), 1'b0, gen_ci};
      send_packet(hdr, 8'($urandom), 1'b0, 1'b0);
      hdr = {2'($urandom), 2'($urandom), 1'b1, gen_ci};
      send_packet(hdr, 8'($urandom), 1'b0, 1'b0);
      set_length(8'd7);
      random_traffic(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // receiver holds off while bytes keep coming, so the block backs up
      set_length(8'd3);
      hold_rsp = 1'b1;
      random_traffic(180);
      set_length(8'($urandom_range(1, 12)));
      random_traffic(180);

      settle();
      if (error_count == 0 && results_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/pccc_pkg.sv
hdl/pccc_in_reg.sv
hdl/pccc_track.sv
hdl/packet_crc_continuity_checker_unit.sv
hdl/pccc_checker.sv
tb/sv/packet_verdict_check.sv
tb/sv/tb.sv
